FILE: sv/pfc_pkg.sv
// ----------------------------------------------------------------------------
// Pixel format converter package
// Shared types, format codes and format decode functions.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned NumLanes       = 4;
  localparam int unsigned DefFifoDepth   = 8;
  localparam int unsigned SampleW        = 16;
  localparam int unsigned FmtW           = 4;
  localparam int unsigned CfgIdxW        = 2;

  typedef enum logic [FmtW-1:0] {
    FmtGrey1,
    FmtGrey2,
    FmtGrey4,
    FmtGrey8,
    FmtGrey16,
    FmtRgb8,
    FmtRgb16,
    FmtGa8,
    FmtGa16,
    FmtRgba8,
    FmtRgba16
  } fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegSrcFormat,
    RegDstFormat
  } reg_idx_e;

  typedef enum logic [1:0] {
    KindGrey,
    KindRgb,
    KindGa,
    KindRgba
  } kind_e;

  typedef struct packed {
    logic [SampleW-1:0] chan_first;
    logic [SampleW-1:0] chan_second;
    logic [SampleW-1:0] chan_third;
    logic [SampleW-1:0] chan_fourth;
  } in_t;

  typedef struct packed {
    logic [SampleW-1:0] out_first;
    logic [SampleW-1:0] out_second;
    logic [SampleW-1:0] out_third;
    logic [SampleW-1:0] out_fourth;
  } out_t;

  // Sample depths are coded as log2 of the bit count: 0 for 1 bit up to 4 for 16 bits.
  typedef struct packed {
    logic [2:0] sw;
    logic [2:0] dw;
  } lane_cfg_t;

  typedef struct packed {
    logic               bad;
    kind_e              dst_kind;
    logic               src_alpha;
    logic [SampleW-1:0] dmax;
  } side_t;

  function automatic kind_e fmt_kind(logic [FmtW-1:0] code);
    kind_e k;
    case (code)
      FmtRgb8, FmtRgb16:   k = KindRgb;
      FmtGa8, FmtGa16:     k = KindGa;
      FmtRgba8, FmtRgba16: k = KindRgba;
      default:             k = KindGrey;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] fmt_wlog(logic [FmtW-1:0] code);
    logic [2:0] w;
    case (code)
      FmtGrey1:                           w = 3'd0;
      FmtGrey2:                           w = 3'd1;
      FmtGrey4:                           w = 3'd2;
      FmtGrey8, FmtRgb8, FmtGa8, FmtRgba8: w = 3'd3;
      default:                            w = 3'd4;
    endcase
    return w;
  endfunction

  function automatic logic [4:0] wlog_bits(logic [2:0] wlog);
    return 5'd1 << wlog;
  endfunction

  function automatic logic [SampleW-1:0] wlog_max(logic [2:0] wlog);
    logic [SampleW:0] one_sh;
    one_sh = (SampleW+1)'(1) << wlog_bits(wlog);
    return SampleW'(one_sh - (SampleW+1)'(1));
  endfunction

  function automatic logic fmt_bad(logic [FmtW-1:0] code);
    return code > FmtRgba16;
  endfunction

endpackage

FILE: sv/pfc_lane.sv
// ----------------------------------------------------------------------------
// Pixel format converter lane
// Rescales one sample from the source depth to the destination depth with
// round-half-up, in three register stages.
// ----------------------------------------------------------------------------
module pfc_lane
  import pfc_pkg::*;
(
  input  logic               clk_i,
  input  logic [SampleW-1:0] v_i,
  input  lane_cfg_t          cfg_i,
  output logic [SampleW-1:0] q_o
);

  // Depths are 2^k-1 with each smaller width dividing the larger ones, so
  // widening is bit replication. Narrowing divides v*D + (S-1)/2 by S = 2^k-1
  // through an estimate that is at most one low and one correction step.

  logic [SampleW-1:0] rep;
  logic [SampleW-1:0] smax_in;
  logic [SampleW-1:0] dmax_in;
  logic [31:0]        x_in;
  logic [31:0]        y_in;
  logic               up_in;

  logic [31:0]        s1_y_q;
  logic               s1_up_q;
  logic [SampleW-1:0] s1_rep_q;
  logic [2:0]         s1_sw_q;

  logic [32:0]        t2;
  logic [32:0]        q1_full;
  logic [31:0]        s2_y_q;
  logic [SampleW-1:0] s2_q1_q;
  logic               s2_up_q;
  logic [SampleW-1:0] s2_rep_q;
  logic [2:0]         s2_sw_q;

  logic [31:0]        qs3;
  logic [31:0]        r3;
  logic [SampleW-1:0] smax3;
  logic [SampleW-1:0] q_d;

  always_comb begin
    case (cfg_i.sw)
      3'd0:    rep = {16{v_i[0]}};
      3'd1:    rep = {8{v_i[1:0]}};
      3'd2:    rep = {4{v_i[3:0]}};
      3'd3:    rep = {2{v_i[7:0]}};
      default: rep = v_i;
    endcase
    smax_in = wlog_max(cfg_i.sw);
    dmax_in = wlog_max(cfg_i.dw);
    up_in   = cfg_i.dw >= cfg_i.sw;
    x_in    = ({16'd0, v_i} << wlog_bits(cfg_i.dw)) - {16'd0, v_i};
    y_in    = x_in + {17'd0, smax_in[SampleW-1:1]};
  end

  always_ff @(posedge clk_i) begin
    s1_y_q   <= y_in;
    s1_up_q  <= up_in;
    s1_rep_q <= rep & dmax_in;
    s1_sw_q  <= cfg_i.sw;
  end

  always_comb begin
    t2      = {1'b0, s1_y_q} + ({1'b0, s1_y_q} >> wlog_bits(s1_sw_q));
    q1_full = t2 >> wlog_bits(s1_sw_q);
  end

  always_ff @(posedge clk_i) begin
    s2_y_q   <= s1_y_q;
    s2_q1_q  <= q1_full[SampleW-1:0];
    s2_up_q  <= s1_up_q;
    s2_rep_q <= s1_rep_q;
    s2_sw_q  <= s1_sw_q;
  end

  always_comb begin
    smax3 = wlog_max(s2_sw_q);
    qs3   = ({16'd0, s2_q1_q} << wlog_bits(s2_sw_q)) - {16'd0, s2_q1_q};
    r3    = s2_y_q - qs3;
    if (s2_up_q) begin
      q_d = s2_rep_q;
    end else if (r3 >= {16'd0, smax3}) begin
      q_d = s2_q1_q + 16'd1;
    end else begin
      q_d = s2_q1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q_o <= q_d;
  end

endmodule

FILE: sv/pfc_merge.sv
// ----------------------------------------------------------------------------
// Pixel format converter merge stage
// Combines the four lane results into the destination pixel layout.
// ----------------------------------------------------------------------------
module pfc_merge
  import pfc_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  side_t                           side_i,
  input  logic [NumLanes-1:0][SampleW-1:0] lane_i,
  output logic                            valid_o,
  output out_t                            data_o
);

  logic [SampleW-1:0] max01;
  logic [SampleW-1:0] grey;
  logic [SampleW-1:0] alpha;
  out_t               data_d;

  always_comb begin
    max01 = (lane_i[1] > lane_i[0]) ? lane_i[1] : lane_i[0];
    grey  = (lane_i[2] > max01) ? lane_i[2] : max01;
    alpha = side_i.src_alpha ? lane_i[3] : side_i.dmax;
    data_d = '0;
    if (!side_i.bad) begin
      case (side_i.dst_kind)
        KindGrey: begin
          data_d.out_first = grey;
        end
        KindGa: begin
          data_d.out_first  = grey;
          data_d.out_second = alpha;
        end
        KindRgb: begin
          data_d.out_first  = lane_i[0];
          data_d.out_second = lane_i[1];
          data_d.out_third  = lane_i[2];
        end
        default: begin
          data_d.out_first  = lane_i[0];
          data_d.out_second = lane_i[1];
          data_d.out_third  = lane_i[2];
          data_d.out_fourth = alpha;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_o <= data_d;
  end

endmodule

FILE: sv/pfc_fifo.sv
// ----------------------------------------------------------------------------
// Pixel format converter output queue
// Holds finished pixels until the receiver takes them.
// ----------------------------------------------------------------------------
module pfc_fifo
  import pfc_pkg::*;
#(
  parameter int unsigned Depth = DefFifoDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t data_i,
  output logic valid_o,
  input  logic stall_i,
  output out_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            pop;

  assign pop     = valid_o && !stall_i;
  assign valid_o = count_q != '0;
  assign data_o  = mem[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop |-> count_q != CntW'(Depth))
    else $error("output queue written while full");

endmodule

FILE: sv/pixel_format_converter_top.sv
// ----------------------------------------------------------------------------
// Pixel format converter
// Converts one pixel per beat between grey, RGB, grey+alpha and RGBA formats
// at 1 to 16 bits per sample, with round-half-up rescaling of every channel.
// ----------------------------------------------------------------------------
// Input beats arrive on in_valid_i/in_stall_o with all four source samples in
// in_data_i; results leave on out_valid_o/out_stall_i, one pixel per input.
// The source and destination formats are set through the write port; the user must
// do so only while no pixel is in flight, which the block itself does not enforce.
// A pixel accepted at a rising edge passes through one decode and clip
// stage, three stages in each of the four rescaling lanes, one merge stage
// and the output queue before it can be taken.
// With the receiver ready the block takes one pixel every cycle while in_stall_o is low.
// The output queue holds FifoDepth pixels; in_stall_o rises when that many
// pixels are accepted and not yet delivered, so a stalled receiver holds the
// input back after at most FifoDepth beats and nothing is ever dropped.
// Reset empties the pipeline and the queue, sets both formats to 8-bit grey
// and holds in_stall_o high while reset is asserted.
// ----------------------------------------------------------------------------
module pixel_format_converter_top
  import pfc_pkg::*;
#(
  parameter int unsigned FifoDepth = DefFifoDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [FmtW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o
);

  localparam int unsigned CntW   = $clog2(FifoDepth + 1);
  localparam int unsigned LaneLat = 3;

  logic [FmtW-1:0] src_q;
  logic [FmtW-1:0] dst_q;

  logic            in_acc;
  logic            out_acc;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic            stall_q;
  logic            stall_d;

  kind_e                            sk;
  logic [2:0]                       sw;
  logic [SampleW-1:0]               smax;
  logic [NumLanes-1:0][SampleW-1:0] clip;
  logic [NumLanes-1:0][SampleW-1:0] lane_v_d;
  side_t                            side_d;
  lane_cfg_t                        lcfg_d;

  logic [NumLanes-1:0][SampleW-1:0] lane_v_q;
  lane_cfg_t                        lcfg_q;
  side_t                            side_q [LaneLat+1];
  logic [LaneLat:0]                 vld_q;
  logic [NumLanes-1:0][SampleW-1:0] lane_q;

  logic merge_valid;
  out_t merge_data;

  assign in_acc     = in_valid_i && !stall_q;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign in_stall_o = stall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= FmtGrey8;
      dst_q <= FmtGrey8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSrcFormat: src_q <= cfg_data_i;
        RegDstFormat: dst_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
    stall_d = cnt_d >= CntW'(FifoDepth);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      stall_q <= 1'b1;
    end else begin
      cnt_q   <= cnt_d;
      stall_q <= stall_d;
    end
  end

  always_comb begin
    sk   = fmt_kind(src_q);
    sw   = fmt_wlog(src_q);
    smax = wlog_max(sw);
    clip[0] = (in_data_i.chan_first > smax) ? smax : in_data_i.chan_first;
    clip[1] = (in_data_i.chan_second > smax) ? smax : in_data_i.chan_second;
    clip[2] = (in_data_i.chan_third > smax) ? smax : in_data_i.chan_third;
    clip[3] = (in_data_i.chan_fourth > smax) ? smax : in_data_i.chan_fourth;
    lane_v_d[0] = clip[0];
    if (sk == KindRgb || sk == KindRgba) begin
      lane_v_d[1] = clip[1];
      lane_v_d[2] = clip[2];
    end else begin
      lane_v_d[1] = clip[0];
      lane_v_d[2] = clip[0];
    end
    lane_v_d[3] = (sk == KindGa) ? clip[1] : clip[3];
    lcfg_d.sw = sw;
    lcfg_d.dw = fmt_wlog(dst_q);
    side_d.bad       = fmt_bad(src_q) || fmt_bad(dst_q);
    side_d.dst_kind  = fmt_kind(dst_q);
    side_d.src_alpha = (sk == KindGa) || (sk == KindRgba);
    side_d.dmax      = wlog_max(lcfg_d.dw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LaneLat-1:0], in_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    lane_v_q  <= lane_v_d;
    lcfg_q    <= lcfg_d;
    side_q[0] <= side_d;
    for (int i = 1; i <= LaneLat; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    pfc_lane u_lane (
      .clk_i (clk_i),
      .v_i   (lane_v_q[g]),
      .cfg_i (lcfg_q),
      .q_o   (lane_q[g])
    );
  end

  pfc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[LaneLat]),
    .side_i  (side_q[LaneLat]),
    .lane_i  (lane_q),
    .valid_o (merge_valid),
    .data_o  (merge_data)
  );

  pfc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (merge_valid),
    .data_i  (merge_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("more pixels in flight than the output queue holds");

  a_pipe_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_valid == $past(vld_q[LaneLat]))
    else $error("merged pixel does not match an accepted beat");

  a_out_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("output beat without a pixel in flight");

endmodule

FILE: dv/pixel_format_converter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel format converter testbench
// Drives pixels through every source/destination format pair with random
// samples, idle gaps on both sides and a long output hold-off, predicts each
// converted pixel with an independent integer model of the conversion and
// compares every delivered beat lane by lane against the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_format_converter_top_tb;
  import pfc_pkg::*;

  localparam int unsigned PipeLatency  = 6;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned HoldLen      = 150;
  localparam int unsigned PairBeats    = 16;
  localparam logic [CfgIdxW-1:0] RegUnused2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegUnused3 = 2'd3;
  localparam logic [FmtW-1:0]    FmtFirstBad = 4'd11;
  localparam logic [FmtW-1:0]    FmtLastBad  = 4'd15;

  localparam kind_e KindOf [0:10] = '{
    KindGrey, KindGrey, KindGrey, KindGrey, KindGrey,
    KindRgb, KindRgb, KindGa, KindGa, KindRgba, KindRgba
  };
  localparam int unsigned MaxOf [0:10] = '{
    1, 3, 15, 255, 65535, 255, 65535, 255, 65535, 255, 65535
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [FmtW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_t                in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_t               out_data_o;

  pixel_format_converter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  out_t            expected_pixels[$];
  logic [FmtW-1:0] model_src_fmt = FmtGrey8;
  logic [FmtW-1:0] model_dst_fmt = FmtGrey8;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     error_count = 0;
  int unsigned     pixels_checked = 0;
  int unsigned     settings_used = 0;
  int unsigned     cycle_count = 0;
  int unsigned     in_stall_cycles = 0;
  logic            hold_start = 1'b0;
  bit              hold_seen = 1'b0;
  int unsigned     hold_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && in_stall_o) in_stall_cycles++;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout with %0d pixels outstanding", $time, expected_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_start && !hold_seen) hold_left = HoldLen;
    hold_seen = hold_start;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic longint unsigned clip_sample(logic [SampleW-1:0] v, longint unsigned mx);
    return (v > mx) ? mx : longint'(v);
  endfunction

  function automatic longint unsigned rescale_sample(longint unsigned v, longint unsigned smax,
                                                     longint unsigned dmax);
    return (2 * v * dmax + smax) / (2 * smax);
  endfunction

  function automatic out_t convert_pixel(in_t px, logic [FmtW-1:0] src, logic [FmtW-1:0] dst);
    out_t            res;
    kind_e           sk;
    kind_e           dk;
    longint unsigned smax, dmax, r, g, b, a, grey;
    bit              has_alpha;
    res = '0;
    if (src > FmtRgba16 || dst > FmtRgba16) return res;
    sk = KindOf[src];
    dk = KindOf[dst];
    smax = MaxOf[src];
    dmax = MaxOf[dst];
    r = clip_sample(px.chan_first, smax);
    g = r;
    b = r;
    a = 0;
    has_alpha = 1'b0;
    if (sk == KindRgb || sk == KindRgba) begin
      g = clip_sample(px.chan_second, smax);
      b = clip_sample(px.chan_third, smax);
    end
    if (sk == KindGa) begin
      a = clip_sample(px.chan_second, smax);
      has_alpha = 1'b1;
    end else if (sk == KindRgba) begin
      a = clip_sample(px.chan_fourth, smax);
      has_alpha = 1'b1;
    end
    r = rescale_sample(r, smax, dmax);
    g = rescale_sample(g, smax, dmax);
    b = rescale_sample(b, smax, dmax);
    a = has_alpha ? rescale_sample(a, smax, dmax) : dmax;
    grey = r;
    if (g > grey) grey = g;
    if (b > grey) grey = b;
    case (dk)
      KindGrey: begin
        res.out_first = SampleW'(grey);
      end
      KindGa: begin
        res.out_first  = SampleW'(grey);
        res.out_second = SampleW'(a);
      end
      KindRgb: begin
        res.out_first  = SampleW'(r);
        res.out_second = SampleW'(g);
        res.out_third  = SampleW'(b);
      end
      default: begin
        res.out_first  = SampleW'(r);
        res.out_second = SampleW'(g);
        res.out_third  = SampleW'(b);
        res.out_fourth = SampleW'(a);
      end
    endcase
    return res;
  endfunction

  function automatic in_t pixel(logic [SampleW-1:0] c0, logic [SampleW-1:0] c1,
                                logic [SampleW-1:0] c2, logic [SampleW-1:0] c3);
    in_t px;
    px.chan_first  = c0;
    px.chan_second = c1;
    px.chan_third  = c2;
    px.chan_fourth = c3;
    return px;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample(logic [FmtW-1:0] src);
    int unsigned smax;
    smax = (src > FmtRgba16) ? 65535 : MaxOf[src];
    case ($urandom_range(9))
      0:       return '0;
      1:       return SampleW'(smax);
      2:       return SampleW'(smax + 1);
      3:       return '1;
      4, 5, 6: return SampleW'($urandom_range(smax, 0));
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic void check_lane(string lane, logic [SampleW-1:0] exp,
                                     logic [SampleW-1:0] act);
    if (act !== exp) begin
      error_count++;
      $display("%0t %s mismatch: expected %h, actual %h", $time, lane, exp, act);
    end
  endfunction

  always @(posedge clk_i) begin
    out_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        $display("%0t unexpected beat: expected none, actual %h", $time, out_data_o);
      end else begin
        exp = expected_pixels.pop_front();
        check_lane("out_first", exp.out_first, out_data_o.out_first);
        check_lane("out_second", exp.out_second, out_data_o.out_second);
        check_lane("out_third", exp.out_third, out_data_o.out_third);
        check_lane("out_fourth", exp.out_fourth, out_data_o.out_fourth);
        pixels_checked++;
      end
    end
  end

  task automatic send_pixel(in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_pixels.push_back(convert_pixel(px, model_src_fmt, model_dst_fmt));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [FmtW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == RegSrcFormat) model_src_fmt = data;
    else if (idx == RegDstFormat) model_dst_fmt = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_formats(logic [FmtW-1:0] src, logic [FmtW-1:0] dst);
    settle();
    write_reg(RegSrcFormat, src);
    write_reg(RegDstFormat, dst);
    settings_used++;
  endtask

  task automatic send_random_beats(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(pixel(pick_sample(model_src_fmt), pick_sample(model_src_fmt),
                       pick_sample(model_src_fmt), pick_sample(model_src_fmt)));
    end
  endtask

  task automatic test_reset_formats();
    send_pixel(pixel('0, '0, '0, '0));
    send_pixel(pixel(16'd255, 16'd255, 16'd255, 16'd255));
    send_pixel(pixel('1, '1, '1, '1));
  endtask

  task automatic test_unused_index();
    settle();
    write_reg(RegUnused2, FmtRgba16);
    write_reg(RegUnused3, FmtGrey1);
    send_pixel(pixel(16'd200, 16'h1234, 16'h5678, 16'h9abc));
  endtask

  task automatic test_depth_extremes();
    set_formats(FmtGrey1, FmtGrey16);
    send_pixel(pixel('0, '1, '1, '1));
    send_pixel(pixel(16'd1, '0, '0, '0));
    send_pixel(pixel('1, '0, '0, '0));
    set_formats(FmtGrey16, FmtGrey1);
    send_pixel(pixel(16'd32767, '0, '0, '0));
    send_pixel(pixel(16'd32768, '0, '0, '0));
  endtask

  task automatic test_channel_mapping();
    set_formats(FmtRgba16, FmtGa8);
    send_pixel(pixel(16'd1000, 16'd50000, 16'd20000, 16'd40000));
    send_pixel(pixel(16'd65535, 16'd0, 16'd128, 16'd0));
    set_formats(FmtGa16, FmtRgba8);
    send_pixel(pixel(16'd30000, 16'd257, 16'hffff, 16'hffff));
    set_formats(FmtRgb8, FmtGa16);
    send_pixel(pixel(16'd300, 16'd10, 16'd254, 16'hffff));
    set_formats(FmtGrey4, FmtRgb8);
    send_pixel(pixel(16'd7, '1, '1, '1));
    set_formats(FmtRgba8, FmtRgb16);
    send_pixel(pixel(16'd1, 16'd128, 16'd255, 16'd77));
  endtask

  task automatic test_bad_formats();
    set_formats(FmtFirstBad, FmtRgba16);
    send_pixel(pixel('1, '1, '1, '1));
    set_formats(FmtRgba16, FmtLastBad);
    send_pixel(pixel('1, '1, '1, '1));
  endtask

  task automatic test_all_pairs();
    int unsigned pair_idx;
    pair_idx = 0;
    for (int s = 0; s <= FmtRgba16; s++) begin
      for (int d = 0; d <= FmtRgba16; d++) begin
        if (pair_idx < 40) begin
          send_idle_pct = 28;
          recv_idle_pct = 60;
        end else if (pair_idx < 80) begin
          send_idle_pct = 60;
          recv_idle_pct = 28;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        set_formats(FmtW'(s), FmtW'(d));
        send_random_beats(PairBeats);
        pair_idx++;
      end
    end
  endtask

  task automatic test_bad_random();
    send_idle_pct = 28;
    recv_idle_pct = 28;
    for (int i = 0; i < 4; i++) begin
      if (i[0]) set_formats(FmtW'($urandom_range(FmtRgba16, FmtGrey1)),
                            FmtW'($urandom_range(FmtLastBad, FmtFirstBad)));
      else set_formats(FmtW'($urandom_range(FmtLastBad, FmtFirstBad)),
                       FmtW'($urandom_range(FmtLastBad, FmtGrey1)));
      send_random_beats(8);
    end
  endtask

  task automatic test_backpressure();
    set_formats(FmtRgba8, FmtRgba16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_start <= 1'b1;
    send_random_beats(40);
    hold_start <= 1'b0;
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_formats();
    test_unused_index();
    test_depth_extremes();
    test_channel_mapping();
    test_bad_formats();
    test_all_pairs();
    test_bad_random();
    test_backpressure();
    settle();
    $display("Checked %0d pixels over %0d format settings, all 121 pairs and out-of-range codes.",
             pixels_checked, settings_used);
    $display("Output held off for %0d cycles once; the input stalled on %0d cycles.",
             HoldLen, in_stall_cycles);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pfc_pkg.sv
sv/pfc_lane.sv
sv/pfc_merge.sv
sv/pfc_fifo.sv
sv/pixel_format_converter_top.sv
dv/pixel_format_converter_top_tb.sv
